// File: hw/rtl/pscg_pkg.sv
// shared types and constants for the page to store code generator
`default_nettype none
package pscg_pkg;

	localparam logic [7:0] OP_LDX_IMM = 8'hA2;
	localparam logic [7:0] OP_STX_ABS = 8'h8E;
	localparam logic [7:0] OP_LDY_IMM = 8'hA0;
	localparam logic [7:0] OP_STY_ABS = 8'h8C;
	localparam logic [7:0] OP_LDA_IMM = 8'hA9;
	localparam logic [7:0] OP_STA_ABS = 8'h8D;
	localparam logic [7:0] OP_RTS     = 8'h60;
	localparam logic [7:0] X_VALUE    = 8'h00;
	localparam logic [7:0] Y_VALUE    = 8'h80;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 8;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_LOAD_OP  = 3'd0;
	localparam logic [STEP_W-1:0] STEP_LOAD_VAL = 3'd1;
	localparam logic [STEP_W-1:0] STEP_STORE_OP = 3'd2;
	localparam logic [STEP_W-1:0] STEP_ADDR_LO  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_ADDR_HI  = 3'd4;
	localparam logic [STEP_W-1:0] STEP_RTS      = 3'd5;

	typedef struct packed {
		logic        has_load;
		logic [7:0]  load_op;
		logic [7:0]  load_val;
		logic [7:0]  store_op;
		logic [15:0] addr;
		logic        rts;
	} cmd_t;

endpackage
`default_nettype wire

// File: hw/rtl/page_to_store_code_generator_core.sv
// top level of the page to store code generator
// Turns a page of data bytes into 6502 code that stores each byte at
// consecutive addresses (LDX/LDY once per page, LDA when the value changes,
// STX/STY/STA abs, RTS after the page's last byte). Code comes out one byte
// per cycle while a command is queued and m_tready is high; an item takes 3 to 6
// code bytes: 3 for a bare store, plus 2 with a register load, plus 1 for the
// closing RTS. The single output byte lane sets the rate. Items are accepted while the
// 4-entry command queue has room, so the input can run ahead of the output.
`default_nettype none
module page_to_store_code_generator_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [pscg_pkg::IN_DATA_W-1:0]   s_tdata,  // data_byte, start_address
	input  wire logic                             s_tuser,  // first_of_page
	input  wire logic                             s_tlast,  // last_of_page
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [pscg_pkg::OUT_DATA_W-1:0]       m_tdata,  // code_byte
	output logic                                  m_tlast,  // last_of_run
	output logic                                  m_tuser   // page_end
);

	pscg_pkg::cmd_t push_cmd;
	pscg_pkg::cmd_t head_cmd;
	logic           push;
	logic           pop;
	logic           q_empty;
	logic           q_full;

	pscg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (push),
		.q_cmd    (push_cmd)
	);

	pscg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.empty    (q_empty),
		.full     (q_full)
	);

	pscg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_cmd (head_cmd),
		.q_empty  (q_empty),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

// File: hw/rtl/pscg_front.sv
// front end: accepts items, tracks register state and builds store commands
`default_nettype none
module pscg_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [pscg_pkg::IN_DATA_W-1:0]   s_tdata,  // data_byte, start_address
	input  wire logic                             s_tuser,  // first_of_page
	input  wire logic                             s_tlast,  // last_of_page
	input  wire logic                             q_full,
	output logic                                  q_push,
	output pscg_pkg::cmd_t                        q_cmd
);

	logic [15:0] next_address_q;
	logic        x_need_q;
	logic        y_need_q;
	logic        acc_known_q;
	logic [7:0]  acc_val_q;

	logic [7:0]  data_byte;
	logic [15:0] start_address;
	logic [15:0] addr_eff;
	logic        x_need_eff;
	logic        y_need_eff;
	logic        acc_known_eff;
	logic        is_x;
	logic        is_y;
	logic        a_load;

	assign data_byte     = s_tdata[7:0];
	assign start_address = s_tdata[23:8];
	assign s_tready      = !q_full;
	assign q_push        = s_tvalid && !q_full;

	assign addr_eff      = s_tuser ? start_address : next_address_q;
	assign x_need_eff    = s_tuser || x_need_q;
	assign y_need_eff    = s_tuser || y_need_q;
	assign acc_known_eff = !s_tuser && acc_known_q;
	assign is_x          = data_byte == pscg_pkg::X_VALUE;
	assign is_y          = data_byte == pscg_pkg::Y_VALUE;
	assign a_load        = !acc_known_eff || (acc_val_q != data_byte);

	always_comb begin
		q_cmd.addr = addr_eff;
		q_cmd.rts  = s_tlast;
		if (is_x) begin
			q_cmd.has_load = x_need_eff;
			q_cmd.load_op  = pscg_pkg::OP_LDX_IMM;
			q_cmd.load_val = pscg_pkg::X_VALUE;
			q_cmd.store_op = pscg_pkg::OP_STX_ABS;
		end else if (is_y) begin
			q_cmd.has_load = y_need_eff;
			q_cmd.load_op  = pscg_pkg::OP_LDY_IMM;
			q_cmd.load_val = pscg_pkg::Y_VALUE;
			q_cmd.store_op = pscg_pkg::OP_STY_ABS;
		end else begin
			q_cmd.has_load = a_load;
			q_cmd.load_op  = pscg_pkg::OP_LDA_IMM;
			q_cmd.load_val = data_byte;
			q_cmd.store_op = pscg_pkg::OP_STA_ABS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_address_q <= '0;
			x_need_q       <= 1'b1;
			y_need_q       <= 1'b1;
			acc_known_q    <= 1'b0;
			acc_val_q      <= '0;
		end else if (q_push) begin
			next_address_q <= addr_eff + 16'd1;
			x_need_q       <= x_need_eff && !is_x;
			y_need_q       <= y_need_eff && !is_y;
			if (!is_x && !is_y) begin
				acc_known_q <= 1'b1;
				acc_val_q   <= data_byte;
			end else begin
				acc_known_q <= acc_known_eff;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/pscg_queue.sv
// short command queue between front and back end
`default_nettype none
module pscg_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire pscg_pkg::cmd_t push_cmd,
	input  wire logic           pop,
	output pscg_pkg::cmd_t      head_cmd,
	output logic                empty,
	output logic                full
);

	pscg_pkg::cmd_t                    slot_q [pscg_pkg::QUEUE_DEPTH];
	logic [pscg_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [pscg_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [pscg_pkg::QUEUE_CNT_W-1:0] count_q;
	logic                              do_push;
	logic                              do_pop;

	localparam logic [pscg_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
		pscg_pkg::QUEUE_PTR_W'(pscg_pkg::QUEUE_DEPTH - 1);
	localparam logic [pscg_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
		pscg_pkg::QUEUE_CNT_W'(pscg_pkg::QUEUE_DEPTH);

	assign empty    = count_q == '0;
	assign full     = count_q == CNT_FULL;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/pscg_back.sv
// back end: walks each command and emits one code byte per cycle while m_tready is high
`default_nettype none
module pscg_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire pscg_pkg::cmd_t                   head_cmd,
	input  wire logic                             q_empty,
	output logic                                  q_pop,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [pscg_pkg::OUT_DATA_W-1:0]       m_tdata,  // code_byte
	output logic                                  m_tlast,  // last_of_run
	output logic                                  m_tuser   // page_end
);

	pscg_pkg::cmd_t              cmd_q;
	logic                        busy_q;
	logic [pscg_pkg::STEP_W-1:0] step_q;
	logic                        m_valid_q;
	logic [7:0]                  code_q;
	logic                        last_q;
	logic                        page_end_q;

	logic                        out_free;
	logic                        emit;
	logic [pscg_pkg::STEP_W-1:0] end_step;
	logic                        at_end;
	logic [7:0]                  cur_byte;

	assign out_free = !m_valid_q || m_tready;
	assign emit     = busy_q && out_free;
	assign end_step = cmd_q.rts ? pscg_pkg::STEP_RTS : pscg_pkg::STEP_ADDR_HI;
	assign at_end   = step_q == end_step;
	assign q_pop    = !q_empty && (!busy_q || (emit && at_end));

	always_comb begin
		case (step_q)
			pscg_pkg::STEP_LOAD_OP:  cur_byte = cmd_q.load_op;
			pscg_pkg::STEP_LOAD_VAL: cur_byte = cmd_q.load_val;
			pscg_pkg::STEP_STORE_OP: cur_byte = cmd_q.store_op;
			pscg_pkg::STEP_ADDR_LO:  cur_byte = cmd_q.addr[7:0];
			pscg_pkg::STEP_ADDR_HI:  cur_byte = cmd_q.addr[15:8];
			pscg_pkg::STEP_RTS:      cur_byte = pscg_pkg::OP_RTS;
			default:                 cur_byte = pscg_pkg::OP_RTS;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= head_cmd;
		end
		if (emit) begin
			code_q     <= cur_byte;
			last_q     <= at_end;
			page_end_q <= step_q == pscg_pkg::STEP_RTS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			step_q    <= pscg_pkg::STEP_LOAD_OP;
			m_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
				step_q <= head_cmd.has_load ? pscg_pkg::STEP_LOAD_OP : pscg_pkg::STEP_STORE_OP;
			end else if (emit && at_end) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = code_q;
	assign m_tlast  = last_q;
	assign m_tuser  = page_end_q;

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= pscg_pkg::STEP_RTS)
		else $error("step beyond rts");

	a_rts_only_when_marked: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !cmd_q.rts |-> step_q != pscg_pkg::STEP_RTS)
		else $error("rts step without page end");

	a_page_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && page_end_q |-> last_q && code_q == pscg_pkg::OP_RTS)
		else $error("page end byte is not a closing rts");

endmodule
`default_nettype wire
